// ----- src/eqg_pkg.sv -----
// Shared types, constants and tables for the equatorial to galactic converter.
package eqg_pkg;

    localparam int ANGLE_BITS_DEF      = 24;
    localparam int ROTATION_STAGES_DEF = 24;
    localparam int FIELD_BITS          = 24;
    localparam int VEC_BITS            = 34;
    localparam int SQRT_CELLS          = 31;
    localparam int SQRT_BITS           = 62;

    typedef logic signed [VEC_BITS-1:0] t_vec;
    typedef logic [SQRT_BITS-1:0]       t_sq;

    localparam t_vec CORDIC_GAIN = t_vec'(652032874);

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    function automatic logic signed [31:0] rot_q30(input longint unsigned mag,
                                                   input logic neg);
        longint unsigned m;
        m = (mag * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000;
        return neg ? -(32'(m)) : 32'(m);
    endfunction

    localparam logic signed [31:0] ROT_M [9] = '{
        rot_q30(64'd548755604, 1'b1),  rot_q30(64'd8734370902, 1'b1),
        rot_q30(64'd4838350155, 1'b1), rot_q30(64'd4941094279, 1'b0),
        rot_q30(64'd4448296300, 1'b1), rot_q30(64'd7469822445, 1'b0),
        rot_q30(64'd8676661490, 1'b1), rot_q30(64'd1980763734, 1'b1),
        rot_q30(64'd4559837762, 1'b0)
    };

endpackage

// ----- src/eqg_cordic_cell.sv -----
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
module eqg_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  eqg_pkg::t_vec i_x,
    input  eqg_pkg::t_vec i_y,
    input  eqg_pkg::t_vec i_z,
    output eqg_pkg::t_vec o_x,
    output eqg_pkg::t_vec o_y,
    output eqg_pkg::t_vec o_z
);

    localparam eqg_pkg::t_vec ATAN =
        eqg_pkg::t_vec'({2'b00, eqg_pkg::ATAN_BAM[STAGE]});

    eqg_pkg::t_vec dx, dy, r_x, r_y, r_z;
    logic          ccw;

    assign dx  = i_y >>> STAGE;
    assign dy  = i_x >>> STAGE;
    assign ccw = VECTORING ? !(i_y > 0) : (i_z >= 0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (ccw) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- src/eqg_sqrt_cell.sv -----
// One digit step of the restoring integer square root, registered.
module eqg_sqrt_cell #(
    parameter int K = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  eqg_pkg::t_sq i_v,
    input  eqg_pkg::t_sq i_r,
    output eqg_pkg::t_sq o_v,
    output eqg_pkg::t_sq o_r
);

    localparam eqg_pkg::t_sq BIT = eqg_pkg::t_sq'(1) << (2 * K);

    eqg_pkg::t_sq t, r_v, r_r;

    assign t = i_r + BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_v >= t) begin
                r_v <= i_v - t;
                r_r <= (i_r >> 1) + BIT;
            end else begin
                r_v <= i_v;
                r_r <= i_r >> 1;
            end
        end
    end

    assign o_v = r_v;
    assign o_r = r_r;

endmodule

// ----- src/equatorial_to_galactic.sv -----
// Top level: pipelined J2000 equatorial to galactic coordinate converter.
//
// Input stream s_*: one sky position per item, s_tdata = right ascension
// (bits 23:0, unsigned binary angle) and declination (bits 47:24, signed).
// Output stream m_*: one result per item, m_tdata = galactic longitude
// (bits 23:0, unsigned) and galactic latitude (bits 47:24, signed).
// Both use 2^ANGLE_BITS units per full turn.
//
// Throughput is one item per cycle while the receiver takes results. An
// item passes a chain of CORDIC cells for sine and cosine, the multiplier
// stages of the rotation matrix, 31 square root cells, and a second chain
// of CORDIC cells for both arctangents, each cell one register deep.
//
// Reset clears the valid bits of every stage; items in flight are dropped.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready falls; bubbles in the pipe still let new
// items enter until a result reaches the output register.
module equatorial_to_galactic #(
    parameter int ANGLE_BITS      = eqg_pkg::ANGLE_BITS_DEF,
    parameter int ROTATION_STAGES = eqg_pkg::ROTATION_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // right_ascension, declination
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // galactic_longitude, galactic_latitude
);

    localparam int SH   = 32 - ANGLE_BITS;
    localparam int NS   = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;
    localparam int ISQ  = eqg_pkg::SQRT_CELLS;
    localparam int L    = 2 * NS + ISQ + 9;
    localparam logic [31:0] HALF = (32'd1 << SH) >> 1;
    localparam eqg_pkg::t_vec QT = eqg_pkg::t_vec'(34'sd1 <<< 30);
    localparam eqg_pkg::t_vec HT = eqg_pkg::t_vec'(34'sd1 <<< 31);

    logic en;
    logic r_vld [L];

    assign en       = !r_vld[L-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_tvalid;
            for (int k = 1; k < L; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // angle reduction
    logic [31:0]   a_ra, a_de;
    eqg_pkg::t_vec z_ra, z_de, n_zra, n_zde;
    logic [1:0]    n_flip;
    eqg_pkg::t_vec r_zra, r_zde;
    logic [1:0]    r_flip [NS+1];

    assign a_ra = {8'b0, s_tdata[23:0]} << SH;
    assign a_de = {8'b0, s_tdata[47:24]} << SH;
    assign z_ra = eqg_pkg::t_vec'(signed'(a_ra));
    assign z_de = eqg_pkg::t_vec'(signed'(a_de));

    always_comb begin
        n_zra  = z_ra;
        n_zde  = z_de;
        n_flip = 2'b00;
        if (z_ra > QT) begin
            n_zra = z_ra - HT;
            n_flip[0] = 1'b1;
        end else if (z_ra < -QT) begin
            n_zra = z_ra + HT;
            n_flip[0] = 1'b1;
        end
        if (z_de > QT) begin
            n_zde = z_de - HT;
            n_flip[1] = 1'b1;
        end else if (z_de < -QT) begin
            n_zde = z_de + HT;
            n_flip[1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zra     <= n_zra;
            r_zde     <= n_zde;
            r_flip[0] <= n_flip;
            for (int k = 1; k <= NS; k++) r_flip[k] <= r_flip[k-1];
        end
    end

    // sine and cosine chains
    eqg_pkg::t_vec c_rx [NS+1], c_ry [NS+1], c_rz [NS+1];
    eqg_pkg::t_vec c_dx [NS+1], c_dy [NS+1], c_dz [NS+1];

    assign c_rx[0] = eqg_pkg::CORDIC_GAIN;
    assign c_ry[0] = '0;
    assign c_rz[0] = r_zra;
    assign c_dx[0] = eqg_pkg::CORDIC_GAIN;
    assign c_dy[0] = '0;
    assign c_dz[0] = r_zde;

    for (genvar i = 0; i < NS; i++) begin : g_sc
        eqg_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_ra (
            .i_clk(i_clk), .i_en(en),
            .i_x(c_rx[i]), .i_y(c_ry[i]), .i_z(c_rz[i]),
            .o_x(c_rx[i+1]), .o_y(c_ry[i+1]), .o_z(c_rz[i+1])
        );
        eqg_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_de (
            .i_clk(i_clk), .i_en(en),
            .i_x(c_dx[i]), .i_y(c_dy[i]), .i_z(c_dz[i]),
            .o_x(c_dx[i+1]), .o_y(c_dy[i+1]), .o_z(c_dz[i+1])
        );
    end

    // unit vector and matrix rotation
    logic signed [31:0] cr, sr, cd, sd;
    logic signed [63:0] r_pc, r_ps;
    logic signed [31:0] r_sd;
    logic signed [31:0] r_v [3];
    logic signed [63:0] r_mp [9];
    logic signed [31:0] r_w [3];
    logic signed [65:0] acc [3];

    assign cr = 32'(r_flip[NS][0] ? -c_rx[NS] : c_rx[NS]);
    assign sr = 32'(r_flip[NS][0] ? -c_ry[NS] : c_ry[NS]);
    assign cd = 32'(r_flip[NS][1] ? -c_dx[NS] : c_dx[NS]);
    assign sd = 32'(r_flip[NS][1] ? -c_dy[NS] : c_dy[NS]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = 66'(r_mp[3*i]) + 66'(r_mp[3*i+1]) + 66'(r_mp[3*i+2])
                   + 66'sd536870912;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pc   <= cr * cd;
            r_ps   <= sr * cd;
            r_sd   <= sd;
            r_v[0] <= 32'((r_pc + 64'sd536870912) >>> 30);
            r_v[1] <= 32'((r_ps + 64'sd536870912) >>> 30);
            r_v[2] <= r_sd;
            for (int k = 0; k < 9; k++) r_mp[k] <= eqg_pkg::ROT_M[k] * r_v[k % 3];
            for (int i = 0; i < 3; i++) r_w[i] <= 32'(acc[i] >>> 30);
        end
    end

    // clamp and radicand
    logic signed [31:0] n_zc, r_zc5, r_x5, r_y5;
    logic signed [63:0] sq;
    eqg_pkg::t_sq       r_rad;
    logic signed [31:0] r_dz [ISQ+1], r_dx [ISQ+1], r_dy [ISQ+1];

    always_comb begin
        priority if (r_w[2] > 32'sd1073741824) n_zc = 32'sd1073741824;
        else if (r_w[2] < -32'sd1073741824) n_zc = -32'sd1073741824;
        else n_zc = r_w[2];
    end

    assign sq = r_zc5 * r_zc5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zc5   <= n_zc;
            r_x5    <= r_w[0];
            r_y5    <= r_w[1];
            r_rad   <= eqg_pkg::t_sq'((64'sd1 <<< 60) - sq);
            r_dz[0] <= r_zc5;
            r_dx[0] <= r_x5;
            r_dy[0] <= r_y5;
            for (int k = 1; k <= ISQ; k++) begin
                r_dz[k] <= r_dz[k-1];
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
        end
    end

    // square root chain
    eqg_pkg::t_sq q_v [ISQ+1], q_r [ISQ+1];

    assign q_v[0] = r_rad;
    assign q_r[0] = '0;

    for (genvar k = 0; k < ISQ; k++) begin : g_sq
        eqg_sqrt_cell #(.K(ISQ - 1 - k)) u_sq (
            .i_clk(i_clk), .i_en(en),
            .i_v(q_v[k]), .i_r(q_r[k]),
            .o_v(q_v[k+1]), .o_r(q_r[k+1])
        );
    end

    // arctangent setup
    eqg_pkg::t_vec lt_x, lt_y, ln_x, ln_y;
    eqg_pkg::t_vec n_ltx, n_lty, n_ltz, n_lnx, n_lny, n_lnz;
    eqg_pkg::t_vec r_ltx, r_lty, r_ltz, r_lnx, r_lny, r_lnz;
    logic [1:0]    n_zf;
    logic [1:0]    r_zf [NS+1];

    assign lt_x = eqg_pkg::t_vec'(q_r[ISQ]);
    assign lt_y = eqg_pkg::t_vec'(r_dz[ISQ]);
    assign ln_x = eqg_pkg::t_vec'(r_dx[ISQ]);
    assign ln_y = eqg_pkg::t_vec'(r_dy[ISQ]);

    always_comb begin
        n_zf[0] = (lt_x == 0) && (lt_y == 0);
        n_zf[1] = (ln_x == 0) && (ln_y == 0);
        n_ltx = lt_x;
        n_lty = lt_y;
        n_ltz = '0;
        n_lnx = ln_x;
        n_lny = ln_y;
        n_lnz = '0;
        if (lt_x < 0) begin
            n_ltx = -lt_x;
            n_lty = -lt_y;
            n_ltz = HT;
        end
        if (ln_x < 0) begin
            n_lnx = -ln_x;
            n_lny = -ln_y;
            n_lnz = HT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ltx   <= n_ltx;
            r_lty   <= n_lty;
            r_ltz   <= n_ltz;
            r_lnx   <= n_lnx;
            r_lny   <= n_lny;
            r_lnz   <= n_lnz;
            r_zf[0] <= n_zf;
            for (int k = 1; k <= NS; k++) r_zf[k] <= r_zf[k-1];
        end
    end

    // arctangent chains
    eqg_pkg::t_vec v_tx [NS+1], v_ty [NS+1], v_tz [NS+1];
    eqg_pkg::t_vec v_nx [NS+1], v_ny [NS+1], v_nz [NS+1];

    assign v_tx[0] = r_ltx;
    assign v_ty[0] = r_lty;
    assign v_tz[0] = r_ltz;
    assign v_nx[0] = r_lnx;
    assign v_ny[0] = r_lny;
    assign v_nz[0] = r_lnz;

    for (genvar i = 0; i < NS; i++) begin : g_at
        eqg_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_lat (
            .i_clk(i_clk), .i_en(en),
            .i_x(v_tx[i]), .i_y(v_ty[i]), .i_z(v_tz[i]),
            .o_x(v_tx[i+1]), .o_y(v_ty[i+1]), .o_z(v_tz[i+1])
        );
        eqg_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_lon (
            .i_clk(i_clk), .i_en(en),
            .i_x(v_nx[i]), .i_y(v_ny[i]), .i_z(v_nz[i]),
            .o_x(v_nx[i+1]), .o_y(v_ny[i+1]), .o_z(v_nz[i+1])
        );
    end

    // output rounding
    eqg_pkg::t_vec      lat_z, lon_z;
    logic signed [63:0] lat_t;
    logic [31:0]        lon_t;
    logic [23:0]        r_lon, r_lat;

    assign lat_z = r_zf[NS][0] ? '0 : v_tz[NS];
    assign lon_z = r_zf[NS][1] ? '0 : v_nz[NS];
    assign lat_t = 64'(lat_z) + 64'(HALF);
    assign lon_t = lon_z[31:0] + HALF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat <= lat_t[SH +: 24];
            r_lon <= 24'(lon_t >> SH);
        end
    end

    assign m_tdata = {r_lat, r_lon};

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> r_vld[0])
        else $error("accepted item not in pipeline");

endmodule

// ----- tb/tb_equatorial_to_galactic.sv -----
// Testbench for the equatorial to galactic converter: bit-exact prediction, random stalls.
module tb_equatorial_to_galactic;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY    = 2 * 24 + 40;
    localparam int  STALL_MAX  = 3000;
    localparam int  N_RANDOM   = 1000;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint HALF_T  = 64'sd1 << 31;
    localparam longint QUART_T = 64'sd1 << 30;

    localparam longint ARCTAN_TURNS [32] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001,
        'h00000000, 'h00000000
    };
    localparam longint unsigned GAL_MAG [9] = '{
        64'd548755604, 64'd8734370902, 64'd4838350155,
        64'd4941094279, 64'd4448296300, 64'd7469822445,
        64'd8676661490, 64'd1980763734, 64'd4559837762
    };
    localparam bit GAL_NEG [9] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    typedef struct packed {
        logic signed [23:0] lat;
        logic [23:0]        lon;
    } t_galactic;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // right_ascension, declination
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // galactic_longitude, galactic_latitude

    t_galactic galactic_q[$];
    int        n_errors;
    int        idle_cycles;
    int        gap_pct;
    int        stall_pct;

    equatorial_to_galactic u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint round_q30(input longint p);
        return (p + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint gal_entry(input int k);
        longint unsigned m;
        m = (GAL_MAG[k] * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000;
        return GAL_NEG[k] ? -longint'(m) : longint'(m);
    endfunction

    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = 652032874;
        y = 0;
        z = ang;
        flip = 0;
        if (z > QUART_T) begin
            z -= HALF_T;
            flip = 1;
        end else if (z < -QUART_T) begin
            z += HALF_T;
            flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN_TURNS[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint arc_tan2(input longint y0, input longint x0);
        longint x, y, z, dx, dy;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; z = HALF_T;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ARCTAN_TURNS[i];
            end else begin
                x -= dx; y += dy; z -= ARCTAN_TURNS[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v0);
        longint unsigned v, r, b;
        v = v0;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_galactic to_galactic(input logic [23:0] ra, input logic [23:0] dec);
        longint cr, sr, cd, sd, zc, lon, lat, acc;
        longint v[3];
        longint w[3];
        longint unsigned l32;
        t_galactic g;
        sin_cos(longint'($signed({ra, 8'h00})), cr, sr);
        sin_cos(longint'($signed({dec, 8'h00})), cd, sd);
        v[0] = round_q30(cr * cd);
        v[1] = round_q30(sr * cd);
        v[2] = sd;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += gal_entry(i * 3 + j) * v[j];
            w[i] = round_q30(acc);
        end
        zc = w[2];
        if (zc > ONE_Q30) zc = ONE_Q30;
        if (zc < -ONE_Q30) zc = -ONE_Q30;
        lat = arc_tan2(zc, longint'(int_sqrt(longint'(ONE_Q30 * ONE_Q30 - zc * zc))));
        lon = arc_tan2(w[1], w[0]);
        l32 = longint'(lon) & 64'hFFFF_FFFF;
        g.lon = 24'((l32 + 128) >> 8);
        g.lat = 24'((lat + 128) >>> 8);
        return g;
    endfunction

    function automatic int pick_gap(input int pct);
        int r;
        if ($urandom_range(0, 99) >= pct) return 0;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_position(input logic [23:0] ra, input logic [23:0] dec);
        int gap;
        gap = pick_gap(gap_pct);
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
            s_tdata  = 48'({$urandom, $urandom});
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = {dec, ra};
        do @(posedge i_clk); while (!s_tready);
        galactic_q.push_back(to_galactic(ra, dec));
    endtask

    // receiver: check at the rising edge, redraw tready at the falling edge
    initial begin
        t_galactic got, want;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got = m_tdata;
                if (galactic_q.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    n_errors++;
                end else begin
                    want = galactic_q.pop_front();
                    if (got.lon !== want.lon) begin
                        $error("galactic_longitude: expected %0d, got %0d", want.lon, got.lon);
                        n_errors++;
                    end
                    if (got.lat !== want.lat) begin
                        $error("galactic_latitude: expected %0d, got %0d", want.lat, got.lat);
                        n_errors++;
                    end
                end
            end
            @(negedge i_clk);
            m_tready = (pick_gap(stall_pct) == 0);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("tb_equatorial_to_galactic: done, errors");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [23:0] ras [6];
        logic [23:0] decs [6];
        ras  = '{24'h000000, 24'hFFFFFF, 24'h400000, 24'h800000, 24'hC00000, 24'h5A5A5A};
        decs = '{24'h000000, 24'h400000, 24'hC00000, 24'h7FFFFF, 24'h800000, 24'h3FFFFF};
        gap_pct = 0;
        stall_pct = 0;
        foreach (ras[i]) send_position(ras[i], decs[i]);
        foreach (decs[i]) send_position(ras[(i + 3) % 6], decs[i]);
        // fixed sky positions and two alternating bit patterns
        send_position(24'd13630635, 24'd1267347);
        send_position(24'd4247339,  -24'd1267347);
        send_position(24'd12473195, -24'd1352160);
        send_position(24'hAAAAAA, 24'h555555);
        send_position(24'h555555, 24'hAAAAAA);
    endtask

    task automatic test_random(input int n);
        logic [23:0] dec;
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) begin
                gap_pct   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 60);
                stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 60);
            end
            if ($urandom_range(0, 4) == 0) dec = 24'($urandom);
            else dec = 24'($signed($urandom_range(0, 8388608)) - 32'sd4194304);
            send_position(24'($urandom), dec);
        end
    endtask

    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 90;
        for (int i = 0; i < 100; i++) send_position(24'($urandom), 24'($urandom));
        stall_pct = 0;
    endtask

    initial begin
        int waited;
        n_errors = 0;
        gap_pct  = 0;
        stall_pct = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(N_RANDOM);
        test_backpressure();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        stall_pct = 20;
        wait (galactic_q.size() == 0);
        waited = 0;
        while (waited < 2 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        if (n_errors == 0 && galactic_q.size() == 0) begin
            $display("tb_equatorial_to_galactic: done, clean");
        end else begin
            $display("tb_equatorial_to_galactic: done, errors");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/eqg_pkg.sv
src/eqg_cordic_cell.sv
src/eqg_sqrt_cell.sv
src/equatorial_to_galactic.sv
tb/tb_equatorial_to_galactic.sv
